[hw/rtl/pbs_pkg.sv]
`default_nettype none
package pbs_pkg;

  localparam int PAD_COUNT = 4;
  localparam int KEY_COUNT = 18;
  localparam int HOLD_BITS = 16;

  localparam int BTN_KEYS  = KEY_COUNT - 2;
  localparam int PAD_W     = 2;
  localparam int KEY_W     = $clog2(KEY_COUNT);
  localparam int CNT_DEPTH = PAD_COUNT * KEY_COUNT;
  localparam int ADDR_W    = $clog2(CNT_DEPTH);
  localparam int AXIS_W    = 16;
  localparam int THR_W     = 15;
  localparam int MAP_W     = 64;
  localparam int KEYCODE_W = 5;
  localparam int TICKS_W   = 16;

  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_MAP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = CFG_IDX_W'(1);

  localparam logic [MAP_W-1:0] MAP_RESET = 64'h54BA76FDEC983210;
  localparam logic [THR_W-1:0] THR_RESET = 15'd16384;

  typedef logic [HOLD_BITS-1:0] hold_t;

  // one classified sample on its way from front to back
  typedef struct packed {
    logic [PAD_W-1:0]         pad;
    logic [KEY_COUNT-1:0]     hit;
    logic signed [AXIS_W-1:0] lx;
    logic signed [AXIS_W-1:0] ly;
    logic signed [AXIS_W-1:0] rx;
    logic signed [AXIS_W-1:0] ry;
  } q_entry_t;

  typedef struct packed {
    logic [PAD_W-1:0]         port;
    logic [KEYCODE_W-1:0]     key;
    logic                     rel;
    logic signed [AXIS_W-1:0] px;
    logic signed [AXIS_W-1:0] py;
    logic [TICKS_W-1:0]       ticks;
    logic                     last;
  } event_t;

  function automatic hold_t sat_inc(input hold_t c);
    hold_t r;
    if (c == '1) begin
      r = c;
    end else begin
      r = c + hold_t'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pbs_in_if.sv]
`default_nettype none
interface pbs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [pbs_pkg::PAD_W-1:0]            pad_port;
  logic [15:0]                          button_bits;
  logic signed [pbs_pkg::AXIS_W-1:0]    axis_x;
  logic signed [pbs_pkg::AXIS_W-1:0]    axis_y;
  logic signed [pbs_pkg::AXIS_W-1:0]    axis_z;
  logic signed [pbs_pkg::AXIS_W-1:0]    axis_rx;
  logic signed [pbs_pkg::AXIS_W-1:0]    axis_ry;
  logic signed [pbs_pkg::AXIS_W-1:0]    axis_rz;

  modport source (output valid, pad_port, button_bits, axis_x, axis_y, axis_z,
                  axis_rx, axis_ry, axis_rz, input ready);
  modport sink (input valid, pad_port, button_bits, axis_x, axis_y, axis_z,
                axis_rx, axis_ry, axis_rz, output ready);
endinterface
`default_nettype wire

[hw/rtl/pbs_out_if.sv]
`default_nettype none
interface pbs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [pbs_pkg::PAD_W-1:0]            event_port;
  logic [pbs_pkg::KEYCODE_W-1:0]        key_code;
  logic                                 is_release;
  logic signed [pbs_pkg::AXIS_W-1:0]    pos_x;
  logic signed [pbs_pkg::AXIS_W-1:0]    pos_y;
  logic [pbs_pkg::TICKS_W-1:0]          hold_ticks;
  logic                                 last;

  modport source (output valid, event_port, key_code, is_release, pos_x, pos_y,
                  hold_ticks, last, input ready);
  modport sink (input valid, event_port, key_code, is_release, pos_x, pos_y,
                hold_ticks, last, output ready);
endinterface
`default_nettype wire

[hw/rtl/pbs_front.sv]
`default_nettype none
module pbs_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pbs_in_if.sink                             in_ch,
  input  wire logic [pbs_pkg::MAP_W-1:0]     button_map,
  input  wire logic [pbs_pkg::THR_W-1:0]     threshold,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output pbs_pkg::q_entry_t                  push_data
);

  logic                                    fr_valid_r;
  logic                                    fr_valid_nxt;
  logic [pbs_pkg::PAD_W-1:0]               fr_pad_r;
  logic [pbs_pkg::BTN_KEYS-1:0]            fr_btn_r;
  logic [pbs_pkg::BTN_KEYS-1:0]            fr_btn_nxt;
  logic signed [pbs_pkg::AXIS_W-1:0]       fr_lx_r;
  logic signed [pbs_pkg::AXIS_W-1:0]       fr_ly_r;
  logic signed [pbs_pkg::AXIS_W-1:0]       fr_rx_r;
  logic signed [pbs_pkg::AXIS_W-1:0]       fr_ry_r;
  logic signed [pbs_pkg::AXIS_W-1:0]       rsum;
  logic                                    accept;
  logic                                    pad_ok;
  logic                                    left_act;
  logic                                    right_act;

  function automatic logic outside(input logic signed [pbs_pkg::AXIS_W-1:0] v,
                                   input logic [pbs_pkg::THR_W-1:0] t);
    logic signed [pbs_pkg::AXIS_W:0] ve;
    logic signed [pbs_pkg::AXIS_W:0] tp;
    logic signed [pbs_pkg::AXIS_W:0] tn;
    ve = {v[pbs_pkg::AXIS_W-1], v};
    tp = {2'b00, t};
    tn = -tp;
    return (ve > tp) || (ve < tn);
  endfunction

  assign in_ch.ready = !fr_valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pad_ok      = int'(in_ch.pad_port) < pbs_pkg::PAD_COUNT;

  // logical key i looks at the physical button named by its map nibble
  always_comb begin
    for (int i = 0; i < pbs_pkg::BTN_KEYS; i++) begin
      fr_btn_nxt[i] = in_ch.button_bits[button_map[4*i +: 4]];
    end
  end

  assign rsum = in_ch.axis_rz + in_ch.axis_ry;

  always_comb begin
    if (accept && pad_ok) begin
      fr_valid_nxt = 1'b1;
    end else if (push_ready) begin
      fr_valid_nxt = 1'b0;
    end else begin
      fr_valid_nxt = fr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pad_ok) begin
      fr_pad_r <= in_ch.pad_port;
      fr_btn_r <= fr_btn_nxt;
      fr_lx_r  <= in_ch.axis_x;
      fr_ly_r  <= -in_ch.axis_y;
      fr_rx_r  <= in_ch.axis_z + in_ch.axis_rx;
      fr_ry_r  <= -rsum;
    end
  end

  assign left_act  = outside(fr_lx_r, threshold) || outside(fr_ly_r, threshold);
  assign right_act = outside(fr_rx_r, threshold) || outside(fr_ry_r, threshold);

  assign push_valid     = fr_valid_r;
  assign push_data.pad  = fr_pad_r;
  assign push_data.hit  = {right_act, left_act, fr_btn_r};
  assign push_data.lx   = fr_lx_r;
  assign push_data.ly   = fr_ly_r;
  assign push_data.rx   = fr_rx_r;
  assign push_data.ry   = fr_ry_r;

endmodule
`default_nettype wire

[hw/rtl/pbs_queue.sv]
`default_nettype none
module pbs_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire pbs_pkg::q_entry_t push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output pbs_pkg::q_entry_t      pop_data
);

  pbs_pkg::q_entry_t               ent_r [pbs_pkg::Q_DEPTH];
  logic [pbs_pkg::Q_PTR_W-1:0]     wr_ptr_r;
  logic [pbs_pkg::Q_PTR_W-1:0]     rd_ptr_r;
  logic [pbs_pkg::Q_CNT_W-1:0]     cnt_r;
  logic [pbs_pkg::Q_CNT_W-1:0]     cnt_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = int'(cnt_r) < pbs_pkg::Q_DEPTH;
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + pbs_pkg::Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - pbs_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == pbs_pkg::Q_DEPTH - 1) ? '0 :
                    wr_ptr_r + pbs_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == pbs_pkg::Q_DEPTH - 1) ? '0 :
                    rd_ptr_r + pbs_pkg::Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pbs_back.sv]
`default_nettype none
module pbs_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire pbs_pkg::q_entry_t pop_data,
  pbs_out_if.source              out_ch
);

  localparam logic [pbs_pkg::KEY_W-1:0] KEY_LAST  = pbs_pkg::KEY_W'(pbs_pkg::KEY_COUNT - 1);
  localparam logic [pbs_pkg::KEY_W-1:0] KEY_LEFT  = pbs_pkg::KEY_W'(pbs_pkg::KEY_COUNT - 2);

  // sample walker
  logic                                cur_valid_r;
  pbs_pkg::q_entry_t                   cur_r;
  logic [pbs_pkg::KEY_W-1:0]           key_r;

  // read stage
  logic                                s1_valid_r;
  logic [pbs_pkg::PAD_W-1:0]           s1_pad_r;
  logic [pbs_pkg::KEY_W-1:0]           s1_key_r;
  logic [pbs_pkg::ADDR_W-1:0]          s1_addr_r;
  logic                                s1_hit_r;
  logic                                s1_stick_r;
  logic                                s1_fin_r;
  logic signed [pbs_pkg::AXIS_W-1:0]   s1_px_r;
  logic signed [pbs_pkg::AXIS_W-1:0]   s1_py_r;
  pbs_pkg::hold_t                      rd_cnt_r;
  logic                                rd_vld_r;

  // counter store and its valid bits
  pbs_pkg::hold_t                      cnt_mem [pbs_pkg::CNT_DEPTH];
  logic [pbs_pkg::CNT_DEPTH-1:0]       vld_r;

  // event staging
  logic                                pend_valid_r;
  logic                                pend_valid_nxt;
  pbs_pkg::event_t                     pend_r;
  pbs_pkg::event_t                     pend_nxt;
  logic                                out_valid_r;
  logic                                out_valid_nxt;
  pbs_pkg::event_t                     out_r;
  pbs_pkg::event_t                     out_nxt;
  logic                                out_load;

  logic                                out_free;
  logic                                flush;
  logic                                s2_fire;
  logic                                s1_adv;
  logic                                issue;
  logic                                fin_issue;
  logic [pbs_pkg::ADDR_W-1:0]          rd_addr;
  logic                                is_stick;
  logic signed [pbs_pkg::AXIS_W-1:0]   sel_px;
  logic signed [pbs_pkg::AXIS_W-1:0]   sel_py;

  pbs_pkg::hold_t                      cnt_cur;
  pbs_pkg::hold_t                      cnt_inc;
  pbs_pkg::hold_t                      cnt_new;
  logic                                ev;
  pbs_pkg::event_t                     ev_data;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign flush     = pend_valid_r && pend_r.last && out_free;
  assign s2_fire   = s1_valid_r && out_free && !(pend_valid_r && pend_r.last);
  assign s1_adv    = !s1_valid_r || s2_fire;
  assign issue     = s1_adv && cur_valid_r;
  assign fin_issue = issue && (key_r == KEY_LAST);
  assign pop_ready = !cur_valid_r || fin_issue;

  assign rd_addr = pbs_pkg::ADDR_W'(pbs_pkg::ADDR_W'(cur_r.pad) *
                   pbs_pkg::ADDR_W'(pbs_pkg::KEY_COUNT) + pbs_pkg::ADDR_W'(key_r));
  assign is_stick = key_r >= KEY_LEFT;
  assign sel_px   = (key_r == KEY_LEFT) ? cur_r.lx : cur_r.rx;
  assign sel_py   = (key_r == KEY_LEFT) ? cur_r.ly : cur_r.ry;

  // walk one key per cycle while the read stage can advance, take the next sample as the last key issues
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      key_r       <= '0;
    end else begin
      if (pop_valid && pop_ready) begin
        cur_valid_r <= 1'b1;
        key_r       <= '0;
      end else if (fin_issue) begin
        cur_valid_r <= 1'b0;
      end else if (issue) begin
        key_r <= key_r + pbs_pkg::KEY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur_r <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= cur_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_pad_r   <= cur_r.pad;
      s1_key_r   <= key_r;
      s1_addr_r  <= rd_addr;
      s1_hit_r   <= cur_r.hit[key_r];
      s1_stick_r <= is_stick;
      s1_fin_r   <= key_r == KEY_LAST;
      s1_px_r    <= sel_px;
      s1_py_r    <= sel_py;
      rd_cnt_r   <= cnt_mem[rd_addr];
      rd_vld_r   <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      cnt_mem[s1_addr_r] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (s2_fire) begin
      vld_r[s1_addr_r] <= 1'b1;
    end
  end

  // update one counter and decide on its event
  always_comb begin
    cnt_cur = rd_vld_r ? rd_cnt_r : '0;
    cnt_inc = pbs_pkg::sat_inc(cnt_cur);
    ev_data.port  = s1_pad_r;
    ev_data.key   = pbs_pkg::KEYCODE_W'(s1_key_r);
    ev_data.last  = s1_fin_r;
    if (s1_hit_r) begin
      cnt_new       = cnt_inc;
      ev            = s1_stick_r || (cnt_inc == pbs_pkg::hold_t'(1));
      ev_data.rel   = 1'b0;
      ev_data.ticks = pbs_pkg::TICKS_W'(cnt_inc);
      ev_data.px    = s1_stick_r ? s1_px_r : '0;
      ev_data.py    = s1_stick_r ? s1_py_r : '0;
    end else begin
      cnt_new       = '0;
      ev            = cnt_cur != '0;
      ev_data.rel   = 1'b1;
      ev_data.ticks = pbs_pkg::TICKS_W'(cnt_cur);
      ev_data.px    = '0;
      ev_data.py    = '0;
    end
  end

  // hold one event back until the next one shows whether it was the last
  always_comb begin
    out_load       = 1'b0;
    out_nxt        = pend_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    if (flush) begin
      out_load       = 1'b1;
      pend_valid_nxt = 1'b0;
    end else if (s2_fire) begin
      if (ev) begin
        if (pend_valid_r) begin
          out_load       = 1'b1;
          pend_nxt       = ev_data;
          pend_valid_nxt = 1'b1;
        end else if (s1_fin_r) begin
          out_load = 1'b1;
          out_nxt  = ev_data;
        end else begin
          pend_nxt       = ev_data;
          pend_valid_nxt = 1'b1;
        end
      end else if (s1_fin_r && pend_valid_r) begin
        out_load       = 1'b1;
        out_nxt.last   = 1'b1;
        pend_valid_nxt = 1'b0;
      end
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_port = out_r.port;
  assign out_ch.key_code   = out_r.key;
  assign out_ch.is_release = out_r.rel;
  assign out_ch.pos_x      = out_r.px;
  assign out_ch.pos_y      = out_r.py;
  assign out_ch.hold_ticks = out_r.ticks;
  assign out_ch.last       = out_r.last;

endmodule
`default_nettype wire

[hw/rtl/pad_button_stick_event_scanner_top.sv]
`default_nettype none
// Pad button and stick event scanner. Each input beat is one polled sample of
// one pad (16 raw buttons, six axes); samples for a pad number at or above the
// pad count are dropped with no effect. The front maps logical keys through
// button_map, forms the two sticks with 16-bit wrap and tests them against the
// threshold register; a two-entry queue then hands the sample to the back, which
// walks all 18 keys of that pad, one hold counter per cycle while not stalled,
// through a counter store with one read and one write port (registered read,
// written back from the read stage). When the final key (the right stick) raises
// an event while an earlier event of the same sample is still held back, the
// final event is flushed alone before the next key. Events leave one per beat
// in key order; one event is held in a staging register so that the final event
// of a sample carries last. Stalls on the result side hold the back only; the
// front keeps taking samples until the queue and the front register fill. Hold
// counters clear at reset through per-entry valid bits, so no clearing pass is
// needed. Write configuration only while the block is idle.
module pad_button_stick_event_scanner_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  pbs_in_if.sink                                 in_ch,
  pbs_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [pbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pbs_pkg::MAP_W-1:0]         cfg_wdata
);

  logic [pbs_pkg::MAP_W-1:0]   button_map_r;
  logic [pbs_pkg::THR_W-1:0]   threshold_r;

  logic                        push_valid;
  logic                        push_ready;
  pbs_pkg::q_entry_t           push_data;
  logic                        pop_valid;
  logic                        pop_ready;
  pbs_pkg::q_entry_t           pop_data;

  // configuration registers; bits above a register's width drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_map_r <= pbs_pkg::MAP_RESET;
      threshold_r  <= pbs_pkg::THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pbs_pkg::CFG_BUTTON_MAP: begin
          button_map_r <= cfg_wdata;
        end
        pbs_pkg::CFG_THRESHOLD: begin
          threshold_r <= cfg_wdata[pbs_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // classify the sample
  pbs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .button_map (button_map_r),
    .threshold  (threshold_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouple front and back
  pbs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // advance counters and raise events
  pbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
